// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- design/rkct_pkg.sv -----
// ----------------------------------------------------------------------------
// rkct_pkg
// Types, opcodes and constants of the rectangle keep-out collision table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rkct_pkg;

    // Field widths
    localparam int unsigned OP_W     = 3;
    localparam int unsigned COORD_W  = 11;
    localparam int unsigned SIZE_W   = 10;
    localparam int unsigned MARGIN_W = 4;
    // Coordinate plus size plus margin, with a sign bit to spare
    localparam int unsigned BOUND_W  = 13;

    // Table depth default
    localparam int unsigned MAX_RECTS_DEF = 128;

    // Margin after reset
    localparam logic [MARGIN_W-1:0] MARGIN_RST = 4'd3;

    // Opcodes
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_HARD   = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_SOFT   = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY_HARD = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY_BOTH = 3'd4;

    // One stored rectangle
    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
    } t_rect;

    // Sign-extend a coordinate to bound width
    function automatic logic signed [BOUND_W-1:0] ext_coord(input logic [COORD_W-1:0] c);
        ext_coord = $signed({{(BOUND_W-COORD_W){c[COORD_W-1]}}, c});
    endfunction

    // Zero-extend a size to bound width
    function automatic logic signed [BOUND_W-1:0] ext_size(input logic [SIZE_W-1:0] s);
        ext_size = $signed({{(BOUND_W-SIZE_W){1'b0}}, s});
    endfunction

endpackage

// ----- design/rect_keepout_collision_table_unit.sv -----
// ----------------------------------------------------------------------------
// rect_keepout_collision_table_unit
// Hard and soft rectangle tables with append, clear and margin-grown
// overlap queries, each table held in a synchronous memory.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_ready    i_opcode, i_rect_left, i_rect_top,
//                                             i_rect_width, i_rect_height
//   result    out        o_valid / i_ready    o_hit, o_stored
//   config    in         i_cfg_we             i_cfg_wdata (margin)
//
// Clear, append and unused opcodes pass through accept, execute and result
// load. A query adds a walk of each table it covers before the result load:
// one read a cycle over the used entries, a last compare, then the walk end.
// Reset empties both tables (counts to zero) and sets the margin to 3; no
// memory sweep is needed. A result held back by a stalled output keeps the
// block from finishing the next item, but the next item is still taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rect_keepout_collision_table_unit #(
    parameter int unsigned MAX_RECTS = rkct_pkg::MAX_RECTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config
    input  logic                           i_cfg_we,
    input  logic [rkct_pkg::MARGIN_W-1:0]  i_cfg_wdata,
    // input channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [rkct_pkg::OP_W-1:0]      i_opcode,
    input  logic signed [rkct_pkg::COORD_W-1:0] i_rect_left,
    input  logic signed [rkct_pkg::COORD_W-1:0] i_rect_top,
    input  logic [rkct_pkg::SIZE_W-1:0]    i_rect_width,
    input  logic [rkct_pkg::SIZE_W-1:0]    i_rect_height,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_hit,
    output logic                           o_stored
);

    localparam int unsigned CNT_W  = $clog2(MAX_RECTS + 1);
    localparam int unsigned ADDR_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Control state
    logic [1:0]                       r_state;
    logic [1:0]                       n_state;
    logic [rkct_pkg::MARGIN_W-1:0]    r_margin;
    logic [CNT_W-1:0]                 r_hard_used;
    logic [CNT_W-1:0]                 r_soft_used;
    logic [CNT_W-1:0]                 r_idx;
    logic                             r_tbl;
    logic                             r_both;
    logic                             r_rd_vld;
    logic                             r_rd_tbl;
    logic                             r_hit;
    logic                             r_stored;

    // Latched item and query bounds
    logic [rkct_pkg::OP_W-1:0]        r_op;
    rkct_pkg::t_rect                  r_rect;
    logic signed [rkct_pkg::BOUND_W-1:0] r_right;
    logic signed [rkct_pkg::BOUND_W-1:0] r_bottom;
    logic signed [rkct_pkg::BOUND_W-1:0] r_xl;
    logic signed [rkct_pkg::BOUND_W-1:0] r_yt;

    // Memories and read data
    rkct_pkg::t_rect                  mem_hard [MAX_RECTS];
    rkct_pkg::t_rect                  mem_soft [MAX_RECTS];
    rkct_pkg::t_rect                  r_hard_q;
    rkct_pkg::t_rect                  r_soft_q;

    logic [CNT_W-1:0]                 cur_used;
    logic                             rd_issue;
    logic                             walk_end;
    rkct_pkg::t_rect                  rd_ent;
    logic                             overlap;
    logic signed [rkct_pkg::BOUND_W-1:0] m_ext;
    logic                             out_free;
    logic                             hard_add;
    logic                             soft_add;

    assign o_ready  = i_rst_n && (r_state == ST_IDLE);
    assign out_free = !o_valid || i_ready;
    assign m_ext    = $signed({{(rkct_pkg::BOUND_W-rkct_pkg::MARGIN_W){1'b0}}, r_margin});

    assign hard_add = (r_state == ST_EXEC) && (r_op == rkct_pkg::OP_ADD_HARD)
                      && (r_hard_used < CNT_MAX);
    assign soft_add = (r_state == ST_EXEC) && (r_op == rkct_pkg::OP_ADD_SOFT)
                      && (r_soft_used < CNT_MAX);

    // Walk control: one read a cycle while entries remain
    assign cur_used = r_tbl ? r_soft_used : r_hard_used;
    assign rd_issue = (r_state == ST_WALK) && (r_idx < cur_used);
    assign walk_end = (r_state == ST_WALK) && !rd_issue && !r_rd_vld;

    // Overlap of the entry read last cycle against the grown query
    assign rd_ent  = r_rd_tbl ? r_soft_q : r_hard_q;
    assign overlap = (rkct_pkg::ext_coord(rd_ent.left) < r_right)
                  && (r_xl < rkct_pkg::ext_coord(rd_ent.left) + rkct_pkg::ext_size(rd_ent.width))
                  && (rkct_pkg::ext_coord(rd_ent.top) < r_bottom)
                  && (r_yt < rkct_pkg::ext_coord(rd_ent.top) + rkct_pkg::ext_size(rd_ent.height));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_op == rkct_pkg::OP_QUERY_HARD || r_op == rkct_pkg::OP_QUERY_BOTH) begin
                    n_state = ST_WALK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_WALK: begin
                if (walk_end && !(r_both && !r_tbl)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_margin    <= rkct_pkg::MARGIN_RST;
            r_hard_used <= '0;
            r_soft_used <= '0;
            r_idx       <= '0;
            r_tbl       <= 1'b0;
            r_both      <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_rd_tbl    <= 1'b0;
            r_hit       <= 1'b0;
            r_stored    <= 1'b0;
            o_valid     <= 1'b0;
            o_hit       <= 1'b0;
            o_stored    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_margin <= i_cfg_wdata;
            end

            // Execute: clear, append, or set up the walk
            if (r_state == ST_EXEC) begin
                r_hit    <= 1'b0;
                r_stored <= hard_add || soft_add;
                r_idx    <= '0;
                r_tbl    <= 1'b0;
                r_both   <= (r_op == rkct_pkg::OP_QUERY_BOTH);
                if (r_op == rkct_pkg::OP_CLEAR) begin
                    r_hard_used <= '0;
                    r_soft_used <= '0;
                end
                if (hard_add) begin
                    r_hard_used <= r_hard_used + CNT_ONE;
                end
                if (soft_add) begin
                    r_soft_used <= r_soft_used + CNT_ONE;
                end
            end

            // Walk: advance the address, flag a hit, switch to the soft table
            r_rd_vld <= rd_issue;
            r_rd_tbl <= r_tbl;
            if (rd_issue) begin
                r_idx <= r_idx + CNT_ONE;
            end
            if (r_state == ST_WALK && r_rd_vld && overlap) begin
                r_hit <= 1'b1;
            end
            if (walk_end && r_both && !r_tbl) begin
                r_tbl <= 1'b1;
                r_idx <= '0;
            end

            // Result register: load when free, drop on transfer
            if (r_state == ST_DONE && out_free) begin
                o_valid  <= 1'b1;
                o_hit    <= r_hit;
                o_stored <= r_stored;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Latch the item and form the grown query bounds
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_op          <= i_opcode;
            r_rect.left   <= i_rect_left;
            r_rect.top    <= i_rect_top;
            r_rect.width  <= i_rect_width;
            r_rect.height <= i_rect_height;
        end
        if (r_state == ST_EXEC) begin
            r_right  <= rkct_pkg::ext_coord(r_rect.left) + rkct_pkg::ext_size(r_rect.width)
                        + m_ext;
            r_bottom <= rkct_pkg::ext_coord(r_rect.top) + rkct_pkg::ext_size(r_rect.height)
                        + m_ext;
            r_xl     <= rkct_pkg::ext_coord(r_rect.left) - m_ext;
            r_yt     <= rkct_pkg::ext_coord(r_rect.top) - m_ext;
        end
    end

    // Hard table memory
    always_ff @(posedge i_clk) begin
        if (hard_add) begin
            mem_hard[r_hard_used[ADDR_W-1:0]] <= r_rect;
        end
        if (rd_issue) begin
            r_hard_q <= mem_hard[r_idx[ADDR_W-1:0]];
        end
    end

    // Soft table memory
    always_ff @(posedge i_clk) begin
        if (soft_add) begin
            mem_soft[r_soft_used[ADDR_W-1:0]] <= r_rect;
        end
        if (rd_issue) begin
            r_soft_q <= mem_soft[r_idx[ADDR_W-1:0]];
        end
    end

    // Checks
    `ASSERT_NEVER(a_hard_cnt_bound, i_clk, i_rst_n, r_hard_used > CNT_MAX, "hard count over depth")
    `ASSERT_NEVER(a_soft_cnt_bound, i_clk, i_rst_n, r_soft_used > CNT_MAX, "soft count over depth")
    `ASSERT_NEVER(a_hit_and_stored, i_clk, i_rst_n, o_valid && o_hit && o_stored, "hit with stored")
    `ASSERT_PROP(a_read_in_walk, i_clk, i_rst_n, r_rd_vld |-> $past(r_state) == ST_WALK, "stray read")
    `ASSERT_PROP(a_add_counts, i_clk, i_rst_n, hard_add |=> r_hard_used == $past(r_hard_used) + CNT_ONE, "hard append lost")

endmodule

// ----- verif/rkct_collision_checker.sv -----
// ----------------------------------------------------------------------------
// rkct_collision_checker
// Watches the input, result and margin ports of the collision table. It keeps
// its own copy of both rectangle tables and the margin, and predicts the hit
// and stored flags of every input transfer. Each result transfer is compared
// with the oldest prediction. The failure count and the number of results
// still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rkct_collision_checker
    import rkct_pkg::*;
#(
    parameter int unsigned MAX_RECTS = MAX_RECTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [MARGIN_W-1:0]       i_cfg_wdata,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [OP_W-1:0]           i_opcode,
    input  logic [COORD_W-1:0]        i_rect_left,
    input  logic [COORD_W-1:0]        i_rect_top,
    input  logic [SIZE_W-1:0]         i_rect_width,
    input  logic [SIZE_W-1:0]         i_rect_height,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic                      i_hit,
    input  logic                      i_stored,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic hit;
        logic stored;
    } t_outcome;

    // Shadow of the block state
    t_rect               hard_tab [MAX_RECTS];
    t_rect               soft_tab [MAX_RECTS];
    int unsigned         hard_cnt;
    int unsigned         soft_cnt;
    logic [MARGIN_W-1:0] margin_q;

    t_outcome predicted_outcomes [$];
    int       fail_cnt;

    // Overlap of a stored rectangle with the query grown by the margin
    function automatic logic rect_overlaps(input t_rect o, input t_rect q, input int m);
        int ol, ot, ow, oh;
        int ql, qt, qw, qh;
        ol = $signed(o.left);
        ot = $signed(o.top);
        ow = o.width;
        oh = o.height;
        ql = $signed(q.left);
        qt = $signed(q.top);
        qw = q.width;
        qh = q.height;
        return (ol < ql + qw + m) && (ql - m < ol + ow) &&
               (ot < qt + qh + m) && (qt - m < ot + oh);
    endfunction

    // Walk the written part of one table
    function automatic logic table_hits(input logic soft_sel, input t_rect q);
        int unsigned used;
        used = soft_sel ? soft_cnt : hard_cnt;
        for (int i = 0; i < used; i++) begin
            if (rect_overlaps(soft_sel ? soft_tab[i] : hard_tab[i], q, int'(margin_q)))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one transfer to the shadow state and work out its result
    task automatic predict_collision_outcome(input logic [OP_W-1:0] op, input t_rect q,
                                             output t_outcome res);
        res = '0;
        case (op)
            OP_CLEAR: begin
                hard_cnt = 0;
                soft_cnt = 0;
            end
            OP_ADD_HARD: begin
                if (hard_cnt < MAX_RECTS) begin
                    hard_tab[hard_cnt] = q;
                    hard_cnt++;
                    res.stored = 1'b1;
                end
            end
            OP_ADD_SOFT: begin
                if (soft_cnt < MAX_RECTS) begin
                    soft_tab[soft_cnt] = q;
                    soft_cnt++;
                    res.stored = 1'b1;
                end
            end
            OP_QUERY_HARD: begin
                res.hit = table_hits(1'b0, q);
            end
            OP_QUERY_BOTH: begin
                res.hit = table_hits(1'b0, q) || table_hits(1'b1, q);
            end
            default: begin
            end
        endcase
    endtask

    // Track margin writes, compare results, predict new transfers
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        t_outcome got;
        t_rect    q;
        if (!i_rst_n) begin
            hard_cnt = 0;
            soft_cnt = 0;
            margin_q = MARGIN_RST;
            predicted_outcomes.delete();
            fail_cnt = 0;
        end else begin
            if (i_cfg_we)
                margin_q = i_cfg_wdata;

            if (i_out_valid && i_out_ready) begin
                got.hit    = i_hit;
                got.stored = i_stored;
                if (predicted_outcomes.size() == 0) begin
                    $display("%0t: result transfer with none expected: hit %0b stored %0b",
                             $time, got.hit, got.stored);
                    fail_cnt++;
                end else begin
                    want = predicted_outcomes.pop_front();
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit mismatch, expected %0b, actual %0b",
                                 $time, want.hit, got.hit);
                        fail_cnt++;
                    end
                    if (got.stored !== want.stored) begin
                        $display("%0t: stored mismatch, expected %0b, actual %0b",
                                 $time, want.stored, got.stored);
                        fail_cnt++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                q.left   = i_rect_left;
                q.top    = i_rect_top;
                q.width  = i_rect_width;
                q.height = i_rect_height;
                predict_collision_outcome(i_opcode, q, want);
                predicted_outcomes.push_back(want);
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= predicted_outcomes.size();
    end

endmodule

// ----- verif/tb_rect_keepout_collision_table_unit.sv -----
// ----------------------------------------------------------------------------
// tb_rect_keepout_collision_table_unit
// Drives the collision table with a short directed run (empty tables, edge
// touching under the strict overlap rule, extreme coordinates, zero sizes,
// unused opcodes, clear) and then phases of random traffic: mixed appends and
// queries, table fills past capacity and a long result stall. The margin is
// rewritten between phases while the block is idle. Checking is done by
// rkct_collision_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rect_keepout_collision_table_unit;
    import rkct_pkg::*;

    localparam int unsigned DEPTH          = MAX_RECTS_DEF;
    localparam int          ITEM_TARGET    = 1700;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          LONG_HOLD      = 300;
    localparam int          TAIL_CYCLES    = 270;
    localparam int          FILL_COUNT     = DEPTH + 2;

    // Opcodes the block ignores
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    logic                       clk;
    logic                       rst_n       = 1'b0;
    logic                       cfg_we      = 1'b0;
    logic [MARGIN_W-1:0]        cfg_wdata   = '0;
    logic                       in_valid    = 1'b0;
    logic [OP_W-1:0]            opcode      = OP_CLEAR;
    logic signed [COORD_W-1:0]  rect_left   = '0;
    logic signed [COORD_W-1:0]  rect_top    = '0;
    logic [SIZE_W-1:0]          rect_width  = '0;
    logic [SIZE_W-1:0]          rect_height = '0;
    logic                       out_ready   = 1'b0;
    logic                       in_ready;
    logic                       out_valid;
    logic                       hit;
    logic                       stored;

    int fail_count;
    int pending;
    int idle_cycles  = 0;
    int items_sent   = 0;
    int cur_margin   = MARGIN_RST;
    bit idle_en      = 1'b0;
    bit hold_req     = 1'b0;
    bit hold_active  = 1'b0;

    // Last appended rectangle, used to aim queries at its edges
    int last_l = 0;
    int last_t = 0;
    int last_w = 0;
    int last_h = 0;

    rect_keepout_collision_table_unit #(
        .MAX_RECTS (DEPTH)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_opcode      (opcode),
        .i_rect_left   (rect_left),
        .i_rect_top    (rect_top),
        .i_rect_width  (rect_width),
        .i_rect_height (rect_height),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_hit         (hit),
        .o_stored      (stored)
    );

    rkct_collision_checker #(
        .MAX_RECTS (DEPTH)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_opcode      (opcode),
        .i_rect_left   (rect_left),
        .i_rect_top    (rect_top),
        .i_rect_width  (rect_width),
        .i_rect_height (rect_height),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_hit         (hit),
        .i_stored      (stored),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort when no transfer happens for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: long hold on request, random stalls, or plain acceptance
    initial begin
        forever begin
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                out_ready  <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_active = 1'b0;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Offer one item, with an optional gap first, and hold it until transferred
    task automatic send_item(input logic [OP_W-1:0] op, input int l, input int t,
                             input int w, input int h);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        rect_left   <= l[COORD_W-1:0];
        rect_top    <= t[COORD_W-1:0];
        rect_width  <= w[SIZE_W-1:0];
        rect_height <= h[SIZE_W-1:0];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (op <= OP_QUERY_BOTH)
            items_sent++;
        if (op == OP_ADD_HARD || op == OP_ADD_SOFT) begin
            last_l = l;
            last_t = t;
            last_w = w;
            last_h = h;
        end
    endtask

    // Drop valid and wait until every predicted result has been transferred
    task automatic wait_drain;
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_margin(input int m);
        cfg_we     <= 1'b1;
        cfg_wdata  <= m[MARGIN_W-1:0];
        cur_margin  = m;
        @(posedge clk);
        cfg_we     <= 1'b0;
    endtask

    // Mostly a crowded window so that hits and misses both occur
    task automatic pick_rect(output int l, output int t, output int w, output int h);
        if ($urandom_range(0, 7) == 0) begin
            l = int'($urandom_range(0, 2047)) - 1024;
            t = int'($urandom_range(0, 2047)) - 1024;
            w = $urandom_range(0, 1023);
            h = $urandom_range(0, 1023);
        end else begin
            l = int'($urandom_range(0, 159)) - 80;
            t = int'($urandom_range(0, 159)) - 80;
            w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
            h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
        end
    endtask

    // Query that just touches or just overlaps one side of the last append
    task automatic pick_edge_query(output int l, output int t, output int w, output int h);
        int sel;
        int d;
        sel = $urandom_range(0, 3);
        d   = $urandom_range(0, 1);
        l   = last_l;
        t   = last_t;
        w   = last_w;
        h   = last_h;
        case (sel)
            0: begin
                w = $urandom_range(0, 40);
                l = last_l + last_w + cur_margin - d;
            end
            1: begin
                w = $urandom_range(0, 40);
                l = last_l - w - cur_margin + d;
            end
            2: begin
                h = $urandom_range(0, 40);
                t = last_t + last_h + cur_margin - d;
            end
            default: begin
                h = $urandom_range(0, 40);
                t = last_t - h - cur_margin + d;
            end
        endcase
        if (l < -1024 || l > 1023 || t < -1024 || t > 1023)
            pick_rect(l, t, w, h);
    endtask

    // Random mix of clears, appends, queries and ignored opcodes
    task automatic run_mix(input int n);
        int               r;
        int               l, t, w, h;
        logic [OP_W-1:0]  op;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_CLEAR;
            else if (r < 33)
                op = OP_ADD_HARD;
            else if (r < 58)
                op = OP_ADD_SOFT;
            else if (r < 76)
                op = OP_QUERY_HARD;
            else if (r < 96)
                op = OP_QUERY_BOTH;
            else
                op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            if ((op == OP_QUERY_HARD || op == OP_QUERY_BOTH) && $urandom_range(0, 9) < 3)
                pick_edge_query(l, t, w, h);
            else
                pick_rect(l, t, w, h);
            send_item(op, l, t, w, h);
        end
    endtask

    // Fill both tables past capacity, then query over the full tables
    task automatic run_fill;
        int l, t, w, h;
        pick_rect(l, t, w, h);
        send_item(OP_CLEAR, l, t, w, h);
        repeat (FILL_COUNT) begin
            pick_rect(l, t, w, h);
            send_item(OP_ADD_HARD, l, t, w, h);
        end
        repeat (FILL_COUNT) begin
            pick_rect(l, t, w, h);
            send_item(OP_ADD_SOFT, l, t, w, h);
        end
        repeat (6) begin
            pick_rect(l, t, w, h);
            send_item($urandom_range(0, 1) ? OP_QUERY_BOTH : OP_QUERY_HARD, l, t, w, h);
        end
        pick_rect(l, t, w, h);
        send_item(OP_CLEAR, l, t, w, h);
    endtask

    // Stall the result side for a long stretch while items keep coming
    task automatic run_hold;
        int l, t, w, h;
        idle_en  = 1'b0;
        hold_req = 1'b1;
        while (!hold_active) @(posedge clk);
        repeat (12) begin
            pick_rect(l, t, w, h);
            send_item($urandom_range(0, 1) ? OP_ADD_HARD : OP_ADD_SOFT, l, t, w, h);
        end
    endtask

    // Stimulus and verdict
    initial begin
        int phase;
        int m;
        phase = 0;

        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty tables, strict edges at the reset margin, extremes
        send_item(OP_QUERY_BOTH, -1024, -1024, 1023, 1023);
        send_item(OP_QUERY_HARD, 1023, 1023, 0, 0);
        send_item(OP_ADD_HARD, 100, 100, 10, 10);
        send_item(OP_QUERY_HARD, 113, 100, 5, 5);
        send_item(OP_QUERY_HARD, 112, 100, 5, 5);
        send_item(OP_QUERY_HARD, 92, 100, 5, 5);
        send_item(OP_QUERY_HARD, 93, 100, 5, 5);
        send_item(OP_QUERY_BOTH, 100, 113, 5, 5);
        send_item(OP_ADD_SOFT, -1024, -1024, 0, 0);
        send_item(OP_QUERY_HARD, -1024, -1024, 0, 0);
        send_item(OP_QUERY_BOTH, -1024, -1024, 0, 0);
        send_item(OP_ADD_HARD, 1023, 1023, 1023, 1023);
        send_item(OP_QUERY_BOTH, 1023, 1023, 1023, 1023);
        send_item(OP_ADD_SOFT, -1, -1, 1023, 1023);
        for (int k = OP_RSVD_FIRST; k <= OP_RSVD_LAST; k++)
            send_item(OP_W'(k), int'($urandom_range(0, 2047)) - 1024,
                      int'($urandom_range(0, 2047)) - 1024,
                      $urandom_range(0, 1023), $urandom_range(0, 1023));
        send_item(OP_CLEAR, 0, 0, 0, 0);
        send_item(OP_QUERY_BOTH, -1024, -1024, 1023, 1023);
        send_item(OP_ADD_SOFT, 0, 0, 0, 0);
        send_item(OP_QUERY_HARD, 0, 0, 0, 0);
        send_item(OP_QUERY_BOTH, 0, 0, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0, 0);

        // Random phases, margin rewritten while idle
        while (items_sent < ITEM_TARGET) begin
            wait_drain();
            case (phase)
                0:       m = 0;
                1:       m = 15;
                default: m = $urandom_range(0, 15);
            endcase
            write_margin(m);
            idle_en = (items_sent + 250 < ITEM_TARGET) && ($urandom_range(0, 4) != 0);
            if (phase == 1 || phase == 4)
                run_fill();
            else if (phase == 2)
                run_hold();
            else
                run_mix($urandom_range(80, 160));
            phase++;
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
